@@ src/audio_jitter_buffer_prefill_gate_macros.svh @@
// ----------------------------------------------------------------------------
// audio jitter buffer prefill gate - assertion macros
// Concurrent check helpers, empty when SYNTH is defined.
// ----------------------------------------------------------------------------
`ifndef AUDIO_JITTER_BUFFER_PREFILL_GATE_MACROS_SVH
`define AUDIO_JITTER_BUFFER_PREFILL_GATE_MACROS_SVH

`ifndef SYNTH
`define AJBPG_ASSERT_SAME(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("jitter buffer check failed");
`define AJBPG_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("jitter buffer sequencing check failed");
`else
`define AJBPG_ASSERT_SAME(lbl, ante, cons)
`define AJBPG_ASSERT_NEXT(lbl, ante, cons)
`endif

`endif

@@ src/ajbpg_pkg.sv @@
// ----------------------------------------------------------------------------
// ajbpg_pkg
// Types and constants shared by the audio jitter buffer prefill gate.
// ----------------------------------------------------------------------------
`default_nettype none

package ajbpg_pkg;

	localparam int BUFFER_SAMPLES = 1024;
	localparam int FRAME_SAMPLES  = 16;

	localparam int SAMPLE_W  = 16;
	localparam int OPCODE_W  = 2;
	localparam int PREFILL_W = 11;
	localparam int REPRIME_W = 8;
	localparam int CFG_W     = 11;
	localparam int CFG_IDX_W = 1;

	localparam int PTR_W  = $clog2(BUFFER_SAMPLES);
	localparam int FILL_W = $clog2(BUFFER_SAMPLES + 1);
	localparam int CNT_W  = $clog2(FRAME_SAMPLES + 1);
	localparam int CMP_W  = (FILL_W > PREFILL_W) ? FILL_W : PREFILL_W;

	localparam logic [OPCODE_W-1:0] OP_PUSH  = 2'd0;
	localparam logic [OPCODE_W-1:0] OP_FRAME = 2'd1;
	localparam logic [OPCODE_W-1:0] OP_FLUSH = 2'd2;

	localparam logic [CFG_IDX_W-1:0] CFG_PREFILL = 1'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_REPRIME = 1'd1;

	localparam logic [PREFILL_W-1:0] PREFILL_RESET = 11'd240;
	localparam logic [REPRIME_W-1:0] REPRIME_RESET = 8'd50;

	typedef struct packed {
		logic [OPCODE_W-1:0]        opcode;
		logic signed [SAMPLE_W-1:0] sample_in;
	} in_item_t;

	typedef struct packed {
		logic signed [SAMPLE_W-1:0] sample_out;
		logic                       frame_last;
		logic                       padded;
		logic                       gate_primed;
	} out_item_t;

endpackage

`default_nettype wire

@@ src/audio_jitter_buffer_prefill_gate.sv @@
// ----------------------------------------------------------------------------
// audio_jitter_buffer_prefill_gate
// Playout jitter buffer for 16-bit mono audio with a prefill gate.
// ----------------------------------------------------------------------------
// An item is taken on a rising edge with start high and busy low. A push
// queues item.sample_in (dropped when the fifo is full), a link reset empties
// the fifo and closes the gate; neither gives a result.
// A frame request plays FRAME_SAMPLES beats on result, each marked by a
// one-cycle result_strobe; the first beat shows once the request has passed
// state_q and the valid_s1 stage, the rest follow on consecutive cycles and
// the last one carries frame_last. busy stays high from a frame request
// until its last beat is out: one sample memory read port walks the frame
// one entry per cycle and one registered read stage sits in front of the
// result ports. The receiver cannot stall, so beats go out at that fixed pace.
// The user must write the prefill level and reprime threshold through wr_en,
// wr_index and wr_data only while the block is idle; it does not enforce this.
// Reset (arst_n low) empties the fifo, closes the gate, restores the register
// defaults and drops any frame in flight. The sample memory needs no clearing.
// ----------------------------------------------------------------------------
`default_nettype none
`include "audio_jitter_buffer_prefill_gate_macros.svh"

module audio_jitter_buffer_prefill_gate
	import ajbpg_pkg::*;
(
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 start,
	output logic                      busy,
	input  wire in_item_t             item,
	output logic                      result_strobe,
	output out_item_t                 result,
	input  wire logic                 wr_en,
	input  wire logic [CFG_IDX_W-1:0] wr_index,
	input  wire logic [CFG_W-1:0]     wr_data
);

	localparam logic ST_IDLE = 1'b0;
	localparam logic ST_PLAY = 1'b1;

	logic [SAMPLE_W-1:0] mem [BUFFER_SAMPLES];

	logic                 state_q;
	logic [PTR_W-1:0]     rd_ptr_q;
	logic [PTR_W-1:0]     wr_ptr_q;
	logic [FILL_W-1:0]    fill_q;
	logic                 primed_q;
	logic [REPRIME_W-1:0] run_q;
	logic [PREFILL_W-1:0] prefill_q;
	logic [REPRIME_W-1:0] reprime_q;
	logic [CNT_W-1:0]     cnt_q;
	logic [CNT_W-1:0]     claim_q;
	logic                 gate_q;

	logic                 valid_s1;
	logic                 last_s1;
	logic                 pad_s1;
	logic [SAMPLE_W-1:0]  rdata_s1;

	logic                 accept;
	logic                 do_push;
	logic                 do_frame;
	logic                 do_flush;
	logic                 fifo_full;
	logic                 open_now;
	logic [CNT_W-1:0]     claim_now;
	logic [REPRIME_W:0]   run_inc;
	logic [REPRIME_W-1:0] run_base;
	logic                 primed_next;
	logic [REPRIME_W-1:0] run_next;
	logic                 issue_pad;
	logic                 issue_last;

	assign busy     = (state_q == ST_PLAY) | valid_s1;
	assign accept   = start & ~busy;
	assign do_push  = accept & (item.opcode == OP_PUSH);
	assign do_frame = accept & (item.opcode == OP_FRAME);
	assign do_flush = accept & (item.opcode == OP_FLUSH);

	assign fifo_full = (fill_q == FILL_W'(BUFFER_SAMPLES));

	// gate decision for a frame request, settled when it is taken
	always_comb begin
		open_now  = primed_q | (CMP_W'(fill_q) >= CMP_W'(prefill_q));
		run_base  = primed_q ? run_q : '0;
		claim_now = '0;
		if (open_now) begin
			if (fill_q < FILL_W'(FRAME_SAMPLES)) begin
				claim_now = CNT_W'(fill_q);
			end else begin
				claim_now = CNT_W'(FRAME_SAMPLES);
			end
		end
		run_inc     = {1'b0, run_base} + (REPRIME_W+1)'(1);
		primed_next = open_now;
		run_next    = run_q;
		if (open_now) begin
			if (claim_now == '0) begin
				if (run_inc >= {1'b0, reprime_q}) begin
					primed_next = 1'b0;
					run_next    = '0;
				end else begin
					run_next = run_inc[REPRIME_W-1:0];
				end
			end else begin
				run_next = '0;
			end
		end
	end

	assign issue_pad  = (cnt_q >= claim_q);
	assign issue_last = (cnt_q == CNT_W'(FRAME_SAMPLES - 1));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prefill_q <= PREFILL_RESET;
			reprime_q <= REPRIME_RESET;
		end else if (wr_en) begin
			case (wr_index)
				CFG_PREFILL: prefill_q <= wr_data;
				CFG_REPRIME: reprime_q <= wr_data[REPRIME_W-1:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_IDLE;
			rd_ptr_q <= '0;
			wr_ptr_q <= '0;
			fill_q   <= '0;
			primed_q <= 1'b0;
			run_q    <= '0;
			cnt_q    <= '0;
			claim_q  <= '0;
			gate_q   <= 1'b0;
			valid_s1 <= 1'b0;
			last_s1  <= 1'b0;
			pad_s1   <= 1'b0;
		end else begin
			valid_s1 <= (state_q == ST_PLAY);
			if (do_push && !fifo_full) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(BUFFER_SAMPLES - 1)) ? '0 :
					wr_ptr_q + PTR_W'(1);
				fill_q <= fill_q + FILL_W'(1);
			end
			if (do_flush) begin
				rd_ptr_q <= '0;
				wr_ptr_q <= '0;
				fill_q   <= '0;
				primed_q <= 1'b0;
				run_q    <= '0;
			end
			if (do_frame) begin
				state_q  <= ST_PLAY;
				cnt_q    <= '0;
				claim_q  <= claim_now;
				gate_q   <= primed_next;
				primed_q <= primed_next;
				run_q    <= run_next;
				fill_q   <= fill_q - FILL_W'(claim_now);
			end
			if (state_q == ST_PLAY) begin
				last_s1  <= issue_last;
				pad_s1   <= issue_pad;
				cnt_q    <= cnt_q + CNT_W'(1);
				if (!issue_pad) begin
					rd_ptr_q <= (rd_ptr_q == PTR_W'(BUFFER_SAMPLES - 1)) ? '0 :
						rd_ptr_q + PTR_W'(1);
				end
				if (issue_last) begin
					state_q <= ST_IDLE;
				end
			end
		end
	end

	// sample memory: one write port for pushes, one registered read port
	always_ff @(posedge clk) begin
		if (do_push && !fifo_full) begin
			mem[wr_ptr_q] <= item.sample_in;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_PLAY && !issue_pad) begin
			rdata_s1 <= mem[rd_ptr_q];
		end
	end

	assign result_strobe      = valid_s1;
	assign result.sample_out  = pad_s1 ? '0 : rdata_s1;
	assign result.frame_last  = last_s1;
	assign result.padded      = pad_s1;
	assign result.gate_primed = gate_q;

	// a queued sample only plays through an open gate
	`AJBPG_ASSERT_SAME(a_real_beat_primed, result_strobe && !result.padded, result.gate_primed)
	// the last beat of a frame frees the block
	`AJBPG_ASSERT_NEXT(a_last_frees, result_strobe && result.frame_last, !busy)
	// a taken frame request holds the block
	`AJBPG_ASSERT_NEXT(a_frame_busy, start && !busy && item.opcode == OP_FRAME, busy)
	// the fill never runs past the buffer size
	`AJBPG_ASSERT_SAME(a_fill_bound, 1'b1, fill_q <= FILL_W'(BUFFER_SAMPLES))

endmodule

`default_nettype wire

@@ tb/tb_audio_jitter_buffer_prefill_gate.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_audio_jitter_buffer_prefill_gate
// Drives pushes, frame requests and link resets through the command port
// and keeps its own playout model of the fifo and prefill gate. Every result
// beat is checked field by field against the oldest predicted beat. Several
// register settings are used, among them zero and out-of-range prefill
// levels and an empty-frame run long enough to close the gate.
// ----------------------------------------------------------------------------
module tb_audio_jitter_buffer_prefill_gate;
	import ajbpg_pkg::*;

	localparam logic [OPCODE_W-1:0] OP_UNUSED = 2'd3;
	localparam int FIDX_W = $clog2(FRAME_SAMPLES);

	typedef struct {
		in_item_t    cmd;
		int unsigned gap;
	} pending_t;

	logic                 clk = 1'b0;
	logic                 arst_n = 1'b0;
	logic                 start = 1'b0;
	logic                 busy;
	in_item_t             item = '0;
	logic                 result_strobe;
	out_item_t            result;
	logic                 wr_en = 1'b0;
	logic [CFG_IDX_W-1:0] wr_index = '0;
	logic [CFG_W-1:0]     wr_data = '0;

	pending_t  pending_q[$];
	out_item_t due_beats[$];
	bit        gaps_on = 1'b0;
	int        err_count = 0;

	// playout model state
	logic [SAMPLE_W-1:0]  sample_mem [BUFFER_SAMPLES];
	logic [PTR_W-1:0]     rd_ptr = '0;
	logic [PTR_W-1:0]     wr_ptr = '0;
	int unsigned          fill = 0;
	bit                   primed = 1'b0;
	int unsigned          empty_frames = 0;
	logic [PREFILL_W-1:0] prefill_cfg = PREFILL_RESET;
	logic [REPRIME_W-1:0] reprime_cfg = REPRIME_RESET;

	audio_jitter_buffer_prefill_gate dut (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.item(item),
		.result_strobe(result_strobe),
		.result(result),
		.wr_en(wr_en),
		.wr_index(wr_index),
		.wr_data(wr_data)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	task automatic advance_playout(input in_item_t cmd);
		int unsigned taken;
		logic [SAMPLE_W-1:0] frame_vals [FRAME_SAMPLES];
		out_item_t beat;
		bit silent;
		case (cmd.opcode)
			OP_PUSH: begin
				if (fill < BUFFER_SAMPLES) begin
					sample_mem[wr_ptr] = cmd.sample_in;
					wr_ptr = wr_ptr + PTR_W'(1);
					fill++;
				end
			end
			OP_FLUSH: begin
				rd_ptr = '0;
				wr_ptr = '0;
				fill = 0;
				primed = 1'b0;
				empty_frames = 0;
			end
			OP_FRAME: begin
				silent = !primed && (fill < prefill_cfg);
				taken = 0;
				if (!silent) begin
					if (!primed) begin
						primed = 1'b1;
						empty_frames = 0;
					end
					taken = (fill < FRAME_SAMPLES) ? fill : FRAME_SAMPLES;
					for (int i = 0; i < taken; i++) begin
						frame_vals[i[FIDX_W-1:0]] = sample_mem[rd_ptr];
						rd_ptr = rd_ptr + PTR_W'(1);
					end
					fill -= taken;
					if (taken == 0) begin
						empty_frames = (empty_frames + 1) & 9'h1FF;
						if (empty_frames >= reprime_cfg) begin
							primed = 1'b0;
							empty_frames = 0;
						end
						if (empty_frames > 255)
							empty_frames = 255;
					end else begin
						empty_frames = 0;
					end
				end
				for (int k = 0; k < FRAME_SAMPLES; k++) begin
					beat.frame_last  = (k == FRAME_SAMPLES - 1);
					beat.padded      = (k >= taken);
					beat.sample_out  = (k < taken) ? frame_vals[k[FIDX_W-1:0]] : '0;
					beat.gate_primed = primed;
					due_beats.push_back(beat);
				end
			end
			default: ;
		endcase
	endtask

	// command driver
	always @(posedge clk) begin
		if (arst_n) begin
			if (start && !busy)
				advance_playout(item);
			if (!start || !busy) begin
				if (pending_q.size() != 0 && pending_q[0].gap == 0) begin
					item <= pending_q[0].cmd;
					start <= 1'b1;
					void'(pending_q.pop_front());
				end else begin
					start <= 1'b0;
					if (pending_q.size() != 0)
						pending_q[0].gap--;
				end
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n && wr_en) begin
			case (wr_index)
				CFG_PREFILL: prefill_cfg = wr_data[PREFILL_W-1:0];
				CFG_REPRIME: reprime_cfg = wr_data[REPRIME_W-1:0];
				default: ;
			endcase
		end
	end

	// result monitor
	always @(posedge clk) begin : mon
		out_item_t want;
		if (arst_n && result_strobe) begin
			if (due_beats.size() == 0) begin
				$error("result beat with nothing expected: %p", result);
				err_count++;
			end else begin
				want = due_beats.pop_front();
				if (result.sample_out !== want.sample_out) begin
					$error("sample_out: expected %0d, got %0d", want.sample_out,
						result.sample_out);
					err_count++;
				end
				if (result.frame_last !== want.frame_last) begin
					$error("frame_last: expected %0b, got %0b", want.frame_last,
						result.frame_last);
					err_count++;
				end
				if (result.padded !== want.padded) begin
					$error("padded: expected %0b, got %0b", want.padded, result.padded);
					err_count++;
				end
				if (result.gate_primed !== want.gate_primed) begin
					$error("gate_primed: expected %0b, got %0b", want.gate_primed,
						result.gate_primed);
					err_count++;
				end
			end
		end
	end

	function automatic int unsigned pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (!gaps_on || r < 55)
			return 0;
		if (r < 92)
			return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	task automatic queue_item(input logic [OPCODE_W-1:0] op,
		input logic [SAMPLE_W-1:0] smp);
		pending_t p;
		p.cmd.opcode = op;
		p.cmd.sample_in = smp;
		p.gap = pick_gap();
		pending_q.push_back(p);
	endtask

	function automatic logic [SAMPLE_W-1:0] rand_sample();
		return SAMPLE_W'($urandom_range(0, 16'hFFFF));
	endfunction

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
		@(posedge clk);
		wr_en <= 1'b1;
		wr_index <= idx;
		wr_data <= val;
		@(posedge clk);
		wr_en <= 1'b0;
	endtask

	// wait until every queued command is sent and every predicted beat is played out
	task automatic settle();
		while (pending_q.size() != 0 || start)
			@(posedge clk);
		while (due_beats.size() != 0)
			@(posedge clk);
		repeat (FRAME_SAMPLES + 8) @(posedge clk);
	endtask

	// mostly push bursts followed by frame requests, with empty runs and noise
	task automatic traffic_mix(input int n);
		int issued;
		int r;
		int k;
		int f;
		issued = 0;
		while (issued < n) begin
			r = $urandom_range(0, 99);
			if (r < 68) begin
				k = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 4) : $urandom_range(5, 40);
				f = $urandom_range(1, 3);
				repeat (k) queue_item(OP_PUSH, rand_sample());
				repeat (f) queue_item(OP_FRAME, rand_sample());
				issued += k + f;
			end else if (r < 82) begin
				f = $urandom_range(1, 6);
				repeat (f) queue_item(OP_FRAME, rand_sample());
				issued += f;
			end else if (r < 90) begin
				queue_item(OP_FLUSH, rand_sample());
				issued++;
			end else if (r < 95) begin
				queue_item(OP_UNUSED, rand_sample());
			end else begin
				k = $urandom_range(1, 6);
				repeat (k) queue_item(OP_PUSH, rand_sample());
				issued += k;
			end
		end
	endtask

	initial begin
		logic [CFG_W-1:0] prefill_set [7];
		logic [CFG_W-1:0] reprime_set [7];
		bit               gaps_set [7];
		prefill_set = '{11'd16, 11'd1, 11'd40, 11'd2047, 11'd0, 11'd0, 11'd8};
		reprime_set = '{11'd3, 11'd1, 11'd255, 11'd5, 11'd0, 11'd0, 11'd4};
		gaps_set    = '{1'b1, 1'b0, 1'b1, 1'b1, 1'b0, 1'b1, 1'b1};
		prefill_set[4] = CFG_W'($urandom_range(0, 64));
		reprime_set[4] = CFG_W'($urandom_range(1, 8));

		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset defaults: gate closed, fill far below the prefill level
		queue_item(OP_FRAME, 16'h0000);
		queue_item(OP_UNUSED, 16'h1234);
		queue_item(OP_PUSH, 16'h8000);
		queue_item(OP_PUSH, 16'h7FFF);
		queue_item(OP_FRAME, 16'hFFFF);
		settle();

		// zero prefill opens on the first request
		write_reg(CFG_PREFILL, 11'd0);
		queue_item(OP_FRAME, 16'h0000);
		queue_item(OP_PUSH, 16'h0000);
		queue_item(OP_PUSH, 16'hFFFF);
		queue_item(OP_PUSH, 16'h5555);
		queue_item(OP_PUSH, 16'hAAAA);
		queue_item(OP_FRAME, 16'h0000);
		queue_item(OP_FRAME, 16'h0000);
		settle();

		// upper data bits are dropped, so this is a zero threshold
		write_reg(CFG_REPRIME, 11'h700);
		queue_item(OP_FRAME, 16'h0000);
		queue_item(OP_FRAME, 16'h0000);
		queue_item(OP_PUSH, 16'h0001);
		queue_item(OP_PUSH, 16'h0002);
		queue_item(OP_FLUSH, 16'h0000);
		queue_item(OP_FRAME, 16'h0000);
		settle();

		// empty run that closes the gate, then reopens it
		write_reg(CFG_PREFILL, 11'd0);
		write_reg(CFG_REPRIME, 11'd20);
		gaps_on = 1'b1;
		repeat (3) queue_item(OP_PUSH, rand_sample());
		repeat (23) queue_item(OP_FRAME, rand_sample());
		settle();

		for (int p = 0; p < 7; p++) begin
			write_reg(CFG_PREFILL, prefill_set[p[2:0]]);
			write_reg(CFG_REPRIME, reprime_set[p[2:0]]);
			gaps_on = gaps_set[p[2:0]];
			traffic_mix(32);
			settle();
		end

		repeat (2 * FRAME_SAMPLES) @(posedge clk);
		if (err_count == 0 && due_beats.size() == 0)
			$display("end of test: clean");
		else
			$display("end of test: mismatches");
		$finish;
	end

	initial begin
		#5_000_000;
		$display("end of test: mismatches");
		$finish;
	end

endmodule
